[rtl/core/ftavg_pkg.sv]
// Shared types and constants for the frame time averager.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package ftavg_pkg;

   localparam int CV_W    = 63;
   localparam int TOT_W   = 64;
   localparam int AVG_W   = 40;
   localparam int SUM_W   = 48;
   localparam int RATE_W  = 16;
   localparam int TPS_W   = 32;
   localparam int EVT_W   = 2;

   localparam logic [EVT_W-1:0] EVT_TICK  = 2'd0;
   localparam logic [EVT_W-1:0] EVT_RESET = 2'd1;
   localparam logic [EVT_W-1:0] EVT_START = 2'd2;
   localparam logic [EVT_W-1:0] EVT_STOP  = 2'd3;

   localparam logic [AVG_W-1:0]  AVG_MAX  = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;
   localparam logic [TPS_W-1:0]  TPS_RESET = 32'd10000000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/core/ftavg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ftavg_pkg (div_stat_type).
`timescale 1ns / 1ps

module ftavg_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          numer,
   input  logic [DEN_W-1:0]          denom,
   output logic [NUM_W-1:0]          quot,
   output ftavg_pkg::div_stat_type   stat
);
   import ftavg_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             qbit;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = (rem_sh >= {1'b0, den_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], qbit};
         rem_in = qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/core/frame_time_averager_core.sv]
// Frame time averager top level: event sequencer, frame history, rate window.
// Depends on ftavg_pkg and ftavg_div.
//
//   channel  dir  handshake          carries
//   req_     in   valid / stall      req_type, counter_value
//   rsp_     out  valid / stall      avg_frame_ticks, frame_rate, total_ticks, is_stopped
//   csr_     in   valid / ready      ticks_per_second
//
// One item at a time; the next item is accepted only once the last result is registered.
// A running tick passes EXEC, GAP, SUB, ADD, DIV, DIVW, TOT and DONE (SUB and ADD are
// skipped when the frame is not stored); in DIVW the bit-serial divider works one quotient
// bit per cycle over the 48-bit history sum. With no stored frames DIV goes on to TOT.
// Reset, start, stop and stopped ticks pass EXEC, TOT and DONE; a start from stop adds PAUSE.
// Reset is synchronous; no clearing pass, the fill count guards the history.
// A stalled result waits in the output register; the next item runs and holds in
// its last state until that register frees.
`timescale 1ns / 1ps

module frame_time_averager_core #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ftavg_pkg::EVT_W-1:0]         req_type,
   input  logic [ftavg_pkg::CV_W-1:0]          req_counter_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ftavg_pkg::AVG_W-1:0]         rsp_avg_frame_ticks,
   output logic [ftavg_pkg::RATE_W-1:0]        rsp_frame_rate,
   output logic signed [ftavg_pkg::TOT_W-1:0]  rsp_total_ticks,
   output logic                                rsp_is_stopped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ftavg_pkg::TPS_W-1:0]         csr_ticks_per_second
);
   import ftavg_pkg::*;

   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_PAUSE = 4'd2;
   localparam logic [3:0] ST_GAP   = 4'd3;
   localparam logic [3:0] ST_SUB   = 4'd4;
   localparam logic [3:0] ST_ADD   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_DIVW  = 4'd7;
   localparam logic [3:0] ST_TOT   = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [AVG_W-1:0]  hist_mem [HISTORY_DEPTH];
   logic [AVG_W-1:0]  rd_data_ff;

   logic [3:0]        state_ff, state_in;
   logic [EVT_W-1:0]  evt_ff, evt_in;
   logic [CV_W-1:0]   cv_ff, cv_in;
   logic [TPS_W-1:0]  tps_ff, tps_in;
   logic [AVG_W-1:0]  elapsed_ff, elapsed_in;
   logic [TOT_W-1:0]  scratch_ff, scratch_in;
   logic              keep_ff, keep_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [AVG_W-1:0]  avg_ff, avg_in;
   logic [CV_W-1:0]   last_ff, last_in;
   logic [CV_W-1:0]   cur_ff, cur_in;
   logic [CV_W-1:0]   base_ff, base_in;
   logic [CV_W-1:0]   stop_ff, stop_in;
   logic [TOT_W-1:0]  paused_ff, paused_in;
   logic              stopped_ff, stopped_in;
   logic [RATE_W-1:0] wframes_ff, wframes_in;
   logic [SUM_W-1:0]  wticks_ff, wticks_in;
   logic [RATE_W-1:0] rate_ff, rate_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]  o_avg_ff, o_avg_in;
   logic [RATE_W-1:0] o_rate_ff, o_rate_in;
   logic [TOT_W-1:0]  o_tot_ff, o_tot_in;
   logic              o_stop_ff, o_stop_in;

   logic              mem_we;
   logic              div_start;
   logic [SUM_W-1:0]  div_quot;
   div_stat_type      div_stat;

   logic [TOT_W-1:0]  diff64;
   logic [AVG_W-1:0]  elapsed_c;
   logic [AVG_W-1:0]  gap_c;
   logic [SUM_W:0]    wsum_c;
   logic [SUM_W-1:0]  wsat_c;
   logic [RATE_W-1:0] wfr_c;
   logic              full_c;
   logic [CV_W-1:0]   ref_c;
   logic              out_free;

   ftavg_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (sum_ff),
      .denom (count_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full_c    = (count_ff == CNT_W'(HISTORY_DEPTH));

   always_comb begin
      diff64 = {1'b0, cv_ff} - {1'b0, last_ff};
      if (diff64[TOT_W-1])
         elapsed_c = '0;
      else if (|diff64[TOT_W-2:AVG_W])
         elapsed_c = AVG_MAX;
      else
         elapsed_c = diff64[AVG_W-1:0];

      gap_c  = (elapsed_ff >= avg_ff) ? (elapsed_ff - avg_ff) : (avg_ff - elapsed_ff);
      wsum_c = {1'b0, wticks_ff} + {{(SUM_W - AVG_W + 1){1'b0}}, elapsed_ff};
      wsat_c = wsum_c[SUM_W] ? SUM_MAX : wsum_c[SUM_W-1:0];
      wfr_c  = (wframes_ff != RATE_MAX) ? (wframes_ff + 1'b1) : wframes_ff;
      ref_c  = stopped_ff ? stop_ff : cur_ff;
   end

   always_comb begin
      state_in     = state_ff;
      evt_in       = evt_ff;
      cv_in        = cv_ff;
      tps_in       = tps_ff;
      elapsed_in   = elapsed_ff;
      scratch_in   = scratch_ff;
      keep_in      = keep_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      stop_in      = stop_ff;
      paused_in    = paused_ff;
      stopped_in   = stopped_ff;
      wframes_in   = wframes_ff;
      wticks_in    = wticks_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_avg_in     = o_avg_ff;
      o_rate_in    = o_rate_ff;
      o_tot_in     = o_tot_ff;
      o_stop_in    = o_stop_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         tps_in = csr_ticks_per_second;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               evt_in   = req_type;
               cv_in    = req_counter_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_TOT;
            unique case (evt_ff)
               EVT_TICK: begin
                  if (stopped_ff) begin
                     avg_in = '0;
                  end else begin
                     cur_in     = cv_ff;
                     last_in    = cv_ff;
                     elapsed_in = elapsed_c;
                     state_in   = ST_GAP;
                  end
               end
               EVT_RESET: begin
                  base_in    = cv_ff;
                  last_in    = cv_ff;
                  stop_in    = '0;
                  stopped_in = 1'b0;
               end
               EVT_START: begin
                  if (stopped_ff) begin
                     scratch_in = {1'b0, cv_ff} - {1'b0, stop_ff};
                     last_in    = cv_ff;
                     stop_in    = '0;
                     stopped_in = 1'b0;
                     state_in   = ST_PAUSE;
                  end
               end
               EVT_STOP: begin
                  if (!stopped_ff) begin
                     stop_in    = cv_ff;
                     stopped_in = 1'b1;
                  end
               end
            endcase
         end
         ST_PAUSE: begin
            paused_in = paused_ff + scratch_ff;
            state_in  = ST_TOT;
         end
         ST_GAP: begin
            keep_in    = (gap_c < {{(AVG_W - TPS_W){1'b0}}, tps_ff});
            wframes_in = wfr_c;
            wticks_in  = wsat_c;
            if (wsat_c > {{(SUM_W - TPS_W){1'b0}}, tps_ff}) begin
               rate_in    = wfr_c;
               wframes_in = '0;
               wticks_in  = '0;
            end
            state_in = (gap_c < {{(AVG_W - TPS_W){1'b0}}, tps_ff}) ? ST_SUB : ST_DIV;
         end
         ST_SUB: begin
            if (full_c)
               sum_in = sum_ff - {{(SUM_W - AVG_W){1'b0}}, rd_data_ff};
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in  = sum_ff + {{(SUM_W - AVG_W){1'b0}}, elapsed_ff};
            mem_we  = keep_ff;
            head_in = (head_ff == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            if (!full_c)
               count_in = count_ff + 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = ST_TOT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_stat.done) begin
               avg_in   = div_quot[AVG_W-1:0];
               state_in = ST_TOT;
            end
         end
         ST_TOT: begin
            scratch_in = {1'b0, ref_c} - paused_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_avg_in     = avg_ff;
               o_rate_in    = rate_ff;
               o_tot_in     = scratch_ff - {1'b0, base_ff};
               o_stop_in    = stopped_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tps_ff       <= TPS_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         last_ff      <= '0;
         cur_ff       <= '0;
         base_ff      <= '0;
         stop_ff      <= '0;
         paused_ff    <= '0;
         stopped_ff   <= 1'b0;
         wframes_ff   <= '0;
         wticks_ff    <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         last_ff      <= last_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         stop_ff      <= stop_in;
         paused_ff    <= paused_in;
         stopped_ff   <= stopped_in;
         wframes_ff   <= wframes_in;
         wticks_ff    <= wticks_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      evt_ff     <= evt_in;
      cv_ff      <= cv_in;
      elapsed_ff <= elapsed_in;
      scratch_ff <= scratch_in;
      keep_ff    <= keep_in;
      o_avg_ff   <= o_avg_in;
      o_rate_ff  <= o_rate_in;
      o_tot_ff   <= o_tot_in;
      o_stop_ff  <= o_stop_in;
   end

   // history store; entries read back are used only once the fill count shows it full
   always_ff @(posedge clock) begin
      if (mem_we)
         hist_mem[head_ff] <= elapsed_ff;
      rd_data_ff <= hist_mem[head_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_avg_frame_ticks = o_avg_ff;
   assign rsp_frame_rate      = o_rate_ff;
   assign rsp_total_ticks     = o_tot_ff;
   assign rsp_is_stopped      = o_stop_ff;

endmodule

[dv/tb_frame_time_averager_core.sv]
// Self-checking testbench for frame_time_averager_core: directed and random events
// checked against an in-bench model of the frame timer. Depends on ftavg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_frame_time_averager_core;
   import ftavg_pkg::*;

   localparam int HISTORY_DEPTH  = 64;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [CV_W-1:0] CV_MAX = '1;

   typedef struct packed {
      logic [AVG_W-1:0]  avg_frame_ticks;
      logic [RATE_W-1:0] frame_rate;
      logic [TOT_W-1:0]  total_ticks;
      logic              is_stopped;
   } frame_report_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [EVT_W-1:0]          req_type;
   logic [CV_W-1:0]           req_counter_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [AVG_W-1:0]          rsp_avg_frame_ticks;
   logic [RATE_W-1:0]         rsp_frame_rate;
   logic signed [TOT_W-1:0]   rsp_total_ticks;
   logic                      rsp_is_stopped;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [TPS_W-1:0]          csr_ticks_per_second;

   frame_time_averager_core #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_counter_value(req_counter_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_avg_frame_ticks(rsp_avg_frame_ticks),
      .rsp_frame_rate(rsp_frame_rate),
      .rsp_total_ticks(rsp_total_ticks),
      .rsp_is_stopped(rsp_is_stopped),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_ticks_per_second(csr_ticks_per_second)
   );

   // timer model state
   logic [TPS_W-1:0]  tps_now;
   logic [AVG_W-1:0]  frame_log [HISTORY_DEPTH];
   int unsigned       log_head;
   int unsigned       log_fill;
   logic [SUM_W-1:0]  log_sum;
   logic [AVG_W-1:0]  mean_ticks;
   logic [TOT_W-1:0]  prev_count, now_count, origin_count, halt_count, pause_sum;
   logic              halted;
   logic [RATE_W-1:0] win_frames, shown_rate;
   logic [SUM_W-1:0]  win_ticks;

   frame_report_type  report_q [$];
   frame_report_type  head_report;
   int                errors;
   int unsigned       quiet_cycles;
   bit                idle_on;
   int                hold_asks, hold_seen, hold_left, run_left;
   logic [CV_W-1:0]   clk_now;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void clear_timer_model();
      foreach (frame_log[i]) frame_log[i] = '0;
      tps_now      = TPS_RESET;
      log_head     = 0;
      log_fill     = 0;
      log_sum      = '0;
      mean_ticks   = '0;
      prev_count   = '0;
      now_count    = '0;
      origin_count = '0;
      halt_count   = '0;
      pause_sum    = '0;
      halted       = 1'b0;
      win_frames   = '0;
      win_ticks    = '0;
      shown_rate   = '0;
   endfunction

   function automatic void account_tick(input logic [CV_W-1:0] cv);
      logic [TOT_W-1:0] span;
      logic [AVG_W-1:0] elapsed, gap;
      logic [SUM_W:0]   ticks_sum;
      if (halted) begin
         mean_ticks = '0;
      end else begin
         now_count = {1'b0, cv};
         span = now_count - prev_count;
         if (span[TOT_W-1])
            elapsed = '0;
         else if (span > TOT_W'(AVG_MAX))
            elapsed = AVG_MAX;
         else
            elapsed = span[AVG_W-1:0];
         prev_count = now_count;
         gap = (elapsed >= mean_ticks) ? elapsed - mean_ticks : mean_ticks - elapsed;
         if (gap < tps_now) begin
            if (log_fill >= HISTORY_DEPTH)
               log_sum = log_sum - frame_log[log_head];
            else
               log_fill++;
            frame_log[log_head] = elapsed;
            log_sum = log_sum + elapsed;
            log_head = (log_head + 1) % HISTORY_DEPTH;
         end
         if (win_frames != RATE_MAX)
            win_frames++;
         ticks_sum = win_ticks + elapsed;
         win_ticks = ticks_sum[SUM_W] ? SUM_MAX : ticks_sum[SUM_W-1:0];
         if (win_ticks > tps_now) begin
            shown_rate = win_frames;
            win_frames = '0;
            win_ticks  = '0;
         end
         mean_ticks = (log_fill == 0) ? '0 : AVG_W'(log_sum / SUM_W'(log_fill));
      end
   endfunction

   function automatic frame_report_type predict_event(input logic [EVT_W-1:0] kind,
                                                      input logic [CV_W-1:0] cv);
      frame_report_type r;
      case (kind)
         EVT_TICK: account_tick(cv);
         EVT_RESET: begin
            origin_count = {1'b0, cv};
            prev_count   = {1'b0, cv};
            halt_count   = '0;
            halted       = 1'b0;
         end
         EVT_START: begin
            if (halted) begin
               pause_sum  = pause_sum + {1'b0, cv} - halt_count;
               prev_count = {1'b0, cv};
               halt_count = '0;
               halted     = 1'b0;
            end
         end
         EVT_STOP: begin
            if (!halted) begin
               halt_count = {1'b0, cv};
               halted     = 1'b1;
            end
         end
         default: ;
      endcase
      r.avg_frame_ticks = mean_ticks;
      r.frame_rate      = shown_rate;
      r.total_ticks     = (halted ? halt_count : now_count) - pause_sum - origin_count;
      r.is_stopped      = halted;
      return r;
   endfunction

   function automatic int draw_pause_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 4);
      if (pick < 97) return $urandom_range(5, 30);
      return $urandom_range(60, 200);
   endfunction

   function automatic logic [CV_W-1:0] random_count();
      return CV_W'({$urandom, $urandom});
   endfunction

   task automatic send_event(input logic [EVT_W-1:0] kind, input logic [CV_W-1:0] cv);
      int pause;
      pause = idle_on ? draw_pause_len() : 0;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_counter_value <= cv;
      do @(posedge clock); while (req_stall);
      report_q.push_back(predict_event(kind, cv));
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate_base(input logic [TPS_W-1:0] value);
      settle_block();
      csr_valid            <= 1'b1;
      csr_ticks_per_second <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tps_now = value;
   endtask

   task automatic test_event_basics();
      idle_on = 1'b1;
      send_event(EVT_TICK, 63'd0);
      send_event(EVT_TICK, 63'd1_000_000);
      send_event(EVT_TICK, 63'd1_500_000);
      send_event(EVT_TICK, 63'd30_000_000);    // beyond a second: not stored, closes window
      send_event(EVT_START, 63'd31_000_000);   // ignored while running
      send_event(EVT_STOP, 63'd32_000_000);
      send_event(EVT_STOP, 63'd33_000_000);    // ignored while stopped
      send_event(EVT_TICK, 63'd34_000_000);    // stopped tick clears average
      send_event(EVT_START, 63'd40_000_000);
      send_event(EVT_TICK, 63'd41_000_000);
      send_event(EVT_RESET, 63'd50_000_000);
      send_event(EVT_TICK, 63'd52_000_000);
   endtask

   task automatic test_counter_extremes();
      idle_on = 1'b0;
      send_event(EVT_TICK, CV_MAX);            // elapsed saturates
      send_event(EVT_TICK, '0);                // counter went backwards
      send_event(EVT_STOP, CV_MAX);
      send_event(EVT_START, '0);
      send_event(EVT_RESET, CV_MAX);
      send_event(EVT_TICK, CV_MAX);
   endtask

   task automatic test_rate_settings();
      logic [CV_W-1:0] cv;
      cv = 63'd5000;
      idle_on = 1'b1;
      write_rate_base(32'd1);
      send_event(EVT_RESET, cv);
      send_event(EVT_TICK, cv + 63'd1);
      send_event(EVT_TICK, cv + 63'd2);
      send_event(EVT_TICK, cv + 63'd4);
      write_rate_base('0);
      send_event(EVT_TICK, cv + 63'd4);
      send_event(EVT_TICK, cv + 63'd9);
      write_rate_base('1);
      send_event(EVT_TICK, cv + 63'h4_0000_0009);
      send_event(EVT_TICK, cv + 63'h4_0001_0009);
      write_rate_base(TPS_RESET);
   endtask

   task automatic test_result_backpressure();
      settle_block();
      idle_on = 1'b0;
      clk_now = 63'd100;
      hold_asks++;
      for (int i = 0; i < 12; i++) begin
         clk_now += 63'd250_000;
         send_event(EVT_TICK, clk_now);
      end
      settle_block();
   endtask

   task automatic run_frame_phase(input logic [TPS_W-1:0] tps, input int items,
                                  input bit with_idle);
      logic [63:0] mean_len, len;
      int unsigned pick;
      write_rate_base(tps);
      idle_on = with_idle;
      mean_len = 64'(tps) / $urandom_range(4, 40) + 1;
      if ($urandom_range(0, 3) == 0)
         clk_now = random_count();
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         len = mean_len - mean_len / 4 + 64'($urandom) % (mean_len / 2 + 1);
         if (halted) begin
            if (pick < 60) begin
               clk_now += CV_W'(len * 3);
               send_event(EVT_START, clk_now);
            end else if (pick < 90) begin
               clk_now += CV_W'(len);
               send_event(EVT_TICK, clk_now);
            end else begin
               send_event(EVT_STOP, clk_now);
            end
         end else if (pick < 72) begin
            if ($urandom_range(0, 19) == 0)
               len = len + 64'(tps) + 1;       // late frame
            clk_now += CV_W'(len);
            send_event(EVT_TICK, clk_now);
         end else if (pick < 80) begin
            clk_now += CV_W'(len / 2);
            send_event(EVT_STOP, clk_now);
         end else if (pick < 84) begin
            send_event(EVT_START, clk_now);
         end else if (pick < 89) begin
            clk_now += CV_W'(len / 3);
            send_event(EVT_RESET, clk_now);
         end else if (pick < 95) begin
            clk_now = random_count();
            send_event(EVT_W'($urandom_range(EVT_TICK, EVT_STOP)), clk_now);
         end else begin
            if ($urandom_range(0, 1) == 0)
               clk_now -= CV_W'(len * $urandom_range(1, 8));
            else
               clk_now += CV_W'({$urandom_range(1, 255), $urandom});
            send_event(EVT_TICK, clk_now);
         end
      end
   endtask

   task automatic test_random_frames();
      clk_now = '0;
      run_frame_phase(TPS_RESET, 50, 1'b1);
      run_frame_phase($urandom_range(100, 100000), 50, 1'b1);
      run_frame_phase(32'd1, 40, 1'b1);
      run_frame_phase('1, 50, 1'b0);
      run_frame_phase($urandom, 50, 1'b1);
      run_frame_phase($urandom_range(1000, 20000), 60, 1'b0);
      run_frame_phase($urandom_range(1, 50), 50, 1'b1);
      run_frame_phase(TPS_RESET, 50, 1'b1);
   endtask

   // result side: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
         run_left = draw_pause_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_q.size() == 0) begin
            $error("result item with nothing pending");
            errors++;
         end else begin
            head_report = report_q.pop_front();
            if (rsp_avg_frame_ticks !== head_report.avg_frame_ticks) begin
               $error("avg_frame_ticks expected %0d got %0d",
                      head_report.avg_frame_ticks, rsp_avg_frame_ticks);
               errors++;
            end
            if (rsp_frame_rate !== head_report.frame_rate) begin
               $error("frame_rate expected %0d got %0d",
                      head_report.frame_rate, rsp_frame_rate);
               errors++;
            end
            if (rsp_total_ticks !== head_report.total_ticks) begin
               $error("total_ticks expected %0d got %0d",
                      $signed(head_report.total_ticks), rsp_total_ticks);
               errors++;
            end
            if (rsp_is_stopped !== head_report.is_stopped) begin
               $error("is_stopped expected %0d got %0d",
                      head_report.is_stopped, rsp_is_stopped);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_frame_time_averager_core failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_type             = EVT_TICK;
      req_counter_value    = '0;
      rsp_stall            = 1'b0;
      csr_valid            = 1'b0;
      csr_ticks_per_second = TPS_RESET;
      errors               = 0;
      quiet_cycles         = 0;
      idle_on              = 1'b0;
      hold_asks            = 0;
      hold_seen            = 0;
      hold_left            = 0;
      run_left             = 0;
      clk_now              = '0;
      clear_timer_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_event_basics();
      test_counter_extremes();
      test_rate_settings();
      test_result_backpressure();
      test_random_frames();

      settle_block();
      repeat (100) @(posedge clock);
      if (report_q.size() != 0) begin
         $error("%0d result items never arrived", report_q.size());
         errors++;
      end
      if (errors == 0)
         $display("tb_frame_time_averager_core passed");
      else
         $display("tb_frame_time_averager_core failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/ftavg_pkg.sv
rtl/core/ftavg_div.sv
rtl/core/frame_time_averager_core.sv
dv/tb_frame_time_averager_core.sv
